// ===== rtl/tptb_pkg.sv =====
package tptb_pkg;

  localparam int PAYLOAD_BYTES = 30;
  localparam int LEN_W         = $clog2(PAYLOAD_BYTES + 1);
  localparam int IDX_W         = $clog2(PAYLOAD_BYTES);
  localparam int FREE_W        = 5;
  localparam int QUEUE_DEPTH   = 2;
  localparam int QPTR_W        = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [2:0] {
    OP_APPEND   = 3'd0,
    OP_FINALIZE = 3'd1,
    OP_POLL     = 3'd2,
    OP_SEND     = 3'd3,
    OP_CLEAR    = 3'd4
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [7:0]  elem_bytes;
    logic [7:0]  group_size;
    logic [31:0] value;
    logic [7:0]  packet_type;
    logic [7:0]  end_code;
  } cmd_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EXEC,
    S_APPEND,
    S_EMIT,
    S_SEND_HEAD,
    S_SEND_LEN,
    S_SEND_WAIT,
    S_SEND_DATA,
    S_SEND_END
  } back_state_t;

endpackage

// ===== rtl/tagged_packet_tx_builder.sv =====
// Flow: an accepted request passes the queue, is popped in S_IDLE, decoded in S_EXEC and its result
// registered from S_EMIT; an append that stores a value first writes its tag and value bytes in S_APPEND.
// A send emits the type, length, payload and end bytes, each payload byte read from the payload
// memory in S_SEND_WAIT before S_SEND_DATA puts it out. Requests queue up while the back end is busy.
// Reset: synchronous, active high; clears the packet state, ready flag, queue and output valid
// flag. The payload memory is not cleared and is only read below the fill length.
module tagged_packet_tx_builder (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  op,
  input  logic [7:0]  elem_bytes,
  input  logic [7:0]  group_size,
  input  logic [31:0] value,
  input  logic [7:0]  packet_type,
  input  logic [7:0]  end_code,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        rejected,
  output logic [4:0]  free_space,
  output logic [7:0]  out_byte,
  output logic        ready_res,
  output logic        last
);
  import tptb_pkg::*;

  logic q_full;
  logic q_push;
  logic q_pop;
  logic q_not_empty;
  cmd_t q_in;
  cmd_t q_out;

  tptb_front u_front (
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .op          (op),
    .elem_bytes  (elem_bytes),
    .group_size  (group_size),
    .value       (value),
    .packet_type (packet_type),
    .end_code    (end_code),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_data      (q_in)
  );

  tptb_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .pop_data  (q_out)
  );

  tptb_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_not_empty),
    .q_data     (q_out),
    .q_pop      (q_pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .rejected   (rejected),
    .free_space (free_space),
    .out_byte   (out_byte),
    .ready_res  (ready_res),
    .last       (last)
  );

endmodule

// ===== rtl/tptb_front.sv =====
module tptb_front (
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [2:0]           op,
  input  logic [7:0]           elem_bytes,
  input  logic [7:0]           group_size,
  input  logic [31:0]          value,
  input  logic [7:0]           packet_type,
  input  logic [7:0]           end_code,
  input  logic                 q_full,
  output logic                 q_push,
  output tptb_pkg::cmd_t       q_data
);
  import tptb_pkg::*;

  logic known_op;

  always_comb begin
    unique case (op)
      OP_APPEND, OP_FINALIZE, OP_POLL, OP_SEND, OP_CLEAR: known_op = 1'b1;
      default:                                            known_op = 1'b0;
    endcase
  end

  // Unknown op codes are taken and dropped here, as they produce no result.
  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full && known_op;

  always_comb begin
    q_data.op          = op_t'(op);
    q_data.elem_bytes  = elem_bytes;
    q_data.group_size  = group_size;
    q_data.value       = value;
    q_data.packet_type = packet_type;
    q_data.end_code    = end_code;
  end

endmodule

// ===== rtl/tptb_queue.sv =====
module tptb_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  tptb_pkg::cmd_t push_data,
  output logic           full,
  input  logic           pop,
  output logic           not_empty,
  output tptb_pkg::cmd_t pop_data
);
  import tptb_pkg::*;

  cmd_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full      = (count == QCNT_W'(QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign pop_data  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

// ===== rtl/tptb_back.sv =====
module tptb_back (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           q_valid,
  input  tptb_pkg::cmd_t                 q_data,
  output logic                           q_pop,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           rejected,
  output logic [tptb_pkg::FREE_W-1:0]    free_space,
  output logic [7:0]                     out_byte,
  output logic                           ready_res,
  output logic                           last
);
  import tptb_pkg::*;

  back_state_t state;
  back_state_t state_next;

  cmd_t             cmd;
  logic [7:0]       type_byte;
  logic [7:0]       end_byte;
  logic [LEN_W-1:0] fill_length;
  logic             ready_flag;
  logic [7:0]       group_left;
  logic             group_refused;
  logic             pend_rej;
  logic [2:0]       byte_cnt;
  logic [LEN_W-1:0] idx;

  logic [7:0]       mem [PAYLOAD_BYTES];
  logic [7:0]       mem_q;
  logic             mem_we;
  logic [7:0]       wr_byte;

  logic             can_emit;
  logic             emit;
  logic             e_rej;
  logic [FREE_W-1:0] e_free;
  logic [7:0]       e_byte;
  logic             e_ready;
  logic             e_last;

  logic [LEN_W-1:0] room;
  logic             w_ok;
  logic [8:0]       w_plus;
  logic [16:0]      need;
  logic             gl_zero;
  logic             empty_grp;
  logic             refuse_now;
  logic             app_store;
  logic             app_rej;

  assign can_emit = !out_valid || out_ready;

  // Group checks for an append, evaluated against the state before the item.
  always_comb begin
    room       = LEN_W'(PAYLOAD_BYTES) - fill_length;
    w_ok       = (cmd.elem_bytes == 8'd1) || (cmd.elem_bytes == 8'd2) ||
                 (cmd.elem_bytes == 8'd4);
    w_plus     = {1'b0, cmd.elem_bytes} + 9'd1;
    need       = 17'(cmd.group_size) * 17'(w_plus);
    gl_zero    = (group_left == 8'd0);
    empty_grp  = gl_zero && (cmd.group_size == 8'd0);
    refuse_now = gl_zero ? (!w_ok || (need > 17'(room))) : group_refused;
    app_store  = !empty_grp && !refuse_now && w_ok && (w_plus <= 9'(room));
    app_rej    = empty_grp ? !w_ok : !app_store;
  end

  // Tag byte first, then the value bytes in target order.
  always_comb begin
    wr_byte = cmd.elem_bytes;
    if (byte_cnt != 3'd0) begin
      unique case (cmd.elem_bytes[2:0])
        3'd1: wr_byte = cmd.value[7:0];
        3'd2: wr_byte = (byte_cnt == 3'd1) ? cmd.value[15:8] : cmd.value[7:0];
        default: begin
          unique case (byte_cnt)
            3'd1:    wr_byte = cmd.value[7:0];
            3'd2:    wr_byte = cmd.value[15:8];
            3'd3:    wr_byte = cmd.value[23:16];
            default: wr_byte = cmd.value[31:24];
          endcase
        end
      endcase
    end
  end

  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    mem_we     = 1'b0;
    emit       = 1'b0;
    e_rej      = 1'b0;
    e_free     = '0;
    e_byte     = '0;
    e_ready    = 1'b0;
    e_last     = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (q_valid) begin
          q_pop      = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        unique case (cmd.op)
          OP_APPEND: state_next = app_store ? S_APPEND : S_EMIT;
          OP_SEND:   state_next = S_SEND_HEAD;
          default:   state_next = S_EMIT;
        endcase
      end
      S_APPEND: begin
        mem_we = 1'b1;
        if (byte_cnt == cmd.elem_bytes[2:0]) begin
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        if (can_emit) begin
          emit       = 1'b1;
          e_rej      = (cmd.op == OP_APPEND) && pend_rej;
          e_free     = (cmd.op == OP_APPEND) ? FREE_W'(room) : '0;
          e_byte     = (cmd.op == OP_POLL) ? {7'd0, ready_flag} : 8'd0;
          e_ready    = ready_flag;
          e_last     = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_SEND_HEAD: begin
        if (can_emit) begin
          emit       = 1'b1;
          e_byte     = type_byte;
          state_next = S_SEND_LEN;
        end
      end
      S_SEND_LEN: begin
        if (can_emit) begin
          emit       = 1'b1;
          e_byte     = 8'(fill_length);
          state_next = (fill_length == '0) ? S_SEND_END : S_SEND_WAIT;
        end
      end
      S_SEND_WAIT: begin
        state_next = S_SEND_DATA;
      end
      S_SEND_DATA: begin
        if (can_emit) begin
          emit       = 1'b1;
          e_byte     = mem_q;
          state_next = ((idx + 1'b1) == fill_length) ? S_SEND_END : S_SEND_WAIT;
        end
      end
      S_SEND_END: begin
        if (can_emit) begin
          emit       = 1'b1;
          e_byte     = end_byte;
          e_last     = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      type_byte     <= '0;
      end_byte      <= '0;
      fill_length   <= '0;
      ready_flag    <= 1'b0;
      group_left    <= '0;
      group_refused <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_EXEC) begin
        unique case (cmd.op)
          OP_APPEND: begin
            if (!empty_grp) begin
              group_left    <= (gl_zero ? cmd.group_size : group_left) - 8'd1;
              group_refused <= refuse_now;
            end
          end
          OP_FINALIZE: begin
            type_byte  <= cmd.packet_type;
            end_byte   <= cmd.end_code;
            ready_flag <= 1'b1;
          end
          OP_CLEAR: begin
            type_byte     <= '0;
            end_byte      <= '0;
            fill_length   <= '0;
            group_left    <= '0;
            group_refused <= 1'b0;
          end
          default: begin
          end
        endcase
      end
      if (mem_we) begin
        fill_length <= fill_length + 1'b1;
      end
      if (state == S_SEND_END && emit) begin
        type_byte     <= '0;
        end_byte      <= '0;
        fill_length   <= '0;
        group_left    <= '0;
        group_refused <= 1'b0;
        ready_flag    <= 1'b0;
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cmd <= q_data;
    end
    if (state == S_EXEC) begin
      pend_rej <= app_rej;
      byte_cnt <= '0;
    end else if (mem_we) begin
      byte_cnt <= byte_cnt + 1'b1;
    end
    if (state == S_SEND_LEN) begin
      idx <= '0;
    end else if (state == S_SEND_DATA && emit) begin
      idx <= idx + 1'b1;
    end
    if (emit) begin
      rejected   <= e_rej;
      free_space <= e_free;
      out_byte   <= e_byte;
      ready_res  <= e_ready;
      last       <= e_last;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[fill_length[IDX_W-1:0]] <= wr_byte;
    end
    mem_q <= mem[idx[IDX_W-1:0]];
  end

endmodule
